// ===== rtl/framed_fir_filter_macros.svh =====
// Assertion macros used by the checker file of the framed FIR filter.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef FRAMED_FIR_FILTER_MACROS_SVH
`define FRAMED_FIR_FILTER_MACROS_SVH

// Assertion that is switched off while the synchronous reset is applied.
`define FFIR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked at every edge, reset cycles included.
`define FFIR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ffir_pkg.sv =====
// ----------------------------------------------------------------------------
// ffir_pkg: shared types and constants of the framed FIR filter
// Widths, frame length, the Q16 coefficient table and the pipeline control
// bundle used by every stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffir_pkg;

  // Sample and frame geometry.
  localparam int SAMPLE_W  = 16;
  localparam int TAPS      = 45;
  localparam int HIST_LEN  = TAPS - 1;
  localparam int FRAME_LEN = 128;
  localparam int POS_W     = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

  // Arithmetic widths. The coefficient table is symmetric, so mirrored taps
  // are added before the multiply and only NPAIR products are formed.
  localparam int COEF_W    = 16;
  localparam int PRE_W     = SAMPLE_W + 1;
  localparam int PROD_W    = PRE_W + COEF_W;
  localparam int NPAIR     = (TAPS + 1) / 2;
  localparam int GRP       = 4;
  localparam int NGRP      = (NPAIR + GRP - 1) / GRP;
  localparam int ACC_W     = 40;
  localparam int DIV_SHIFT = 16;
  localparam int QUOT_W    = ACC_W - DIV_SHIFT;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PRE_W-1:0]    pre_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [QUOT_W-1:0]   quot_t;

  // Low-pass coefficients in Q16 (65536 is 1.0), symmetric about the middle tap.
  localparam coef_t COEF_Q16 [TAPS] = '{
       16'sd1705,   -16'sd186,   -16'sd754,  -16'sd1543,  -16'sd2337,
      -16'sd2901,  -16'sd3074,  -16'sd2835,  -16'sd2325,  -16'sd1815,
      -16'sd1606,  -16'sd1898,  -16'sd2691,  -16'sd3736,  -16'sd4575,
      -16'sd4676,  -16'sd3609,  -16'sd1216,   16'sd2289,   16'sd6330,
      16'sd10103,  16'sd12782,  16'sd13750,  16'sd12782,  16'sd10103,
       16'sd6330,   16'sd2289,  -16'sd1216,  -16'sd3609,  -16'sd4676,
      -16'sd4575,  -16'sd3736,  -16'sd2691,  -16'sd1898,  -16'sd1606,
      -16'sd1815,  -16'sd2325,  -16'sd2835,  -16'sd3074,  -16'sd2901,
      -16'sd2337,  -16'sd1543,   -16'sd754,   -16'sd186,   16'sd1705
  };

  // Pipeline control: adv moves every stage, take marks an accepted sample.
  typedef struct packed {
    logic adv;
    logic take;
  } ffir_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/ffir_window.sv =====
// ----------------------------------------------------------------------------
// ffir_window: delay line, frame counter and symmetric pre-add stage
// Holds the earlier samples of the current frame, clears them at each frame
// start and registers the sums of mirrored taps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffir_window (
  input  logic                clk,
  input  logic                rst_n,
  input  ffir_pkg::ffir_ctl_t ctl,
  input  ffir_pkg::sample_t   in_sample,
  output ffir_pkg::pre_t      pre_r [ffir_pkg::NPAIR]
);
  import ffir_pkg::*;

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             frame_start;
  sample_t          hist_r   [HIST_LEN];
  sample_t          hist_nxt [HIST_LEN];
  sample_t          taps     [TAPS];
  pre_t             pre_nxt  [NPAIR];

  // The history counts as zero when the sample opens a new frame.
  assign frame_start = (pos_r == '0);
  assign pos_nxt     = (pos_r == POS_W'(FRAME_LEN - 1)) ? '0 : pos_r + 1'b1;

  // Tap values seen by this sample, and the shifted delay line.
  always_comb begin
    taps[0] = in_sample;
    for (int k = 1; k < TAPS; k++) begin
      taps[k] = frame_start ? '0 : hist_r[k-1];
    end
    for (int k = 0; k < HIST_LEN; k++) begin
      hist_nxt[k] = taps[k];
    end
  end

  // Mirrored taps share one coefficient; the middle tap stands alone.
  always_comb begin
    for (int p = 0; p < NPAIR; p++) begin
      if (p == TAPS - 1 - p) begin
        pre_nxt[p] = PRE_W'(taps[p]);
      end else begin
        pre_nxt[p] = PRE_W'(taps[p]) + PRE_W'(taps[TAPS-1-p]);
      end
    end
  end

  // Frame position and delay line move only on an accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int k = 0; k < HIST_LEN; k++) begin
        hist_r[k] <= '0;
      end
    end else if (ctl.take) begin
      pos_r  <= pos_nxt;
      hist_r <= hist_nxt;
    end
  end

  // Pre-add register.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      pre_r <= pre_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ffir_mac.sv =====
// ----------------------------------------------------------------------------
// ffir_mac: coefficient multiply and registered adder tree
// Multiplies each pre-added pair by its Q16 coefficient, then sums the
// products in two registered levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffir_mac (
  input  logic                clk,
  input  ffir_pkg::ffir_ctl_t ctl,
  input  ffir_pkg::pre_t      pre_r [ffir_pkg::NPAIR],
  output ffir_pkg::acc_t      sum_r
);
  import ffir_pkg::*;

  prod_t prod_r   [NPAIR];
  prod_t prod_nxt [NPAIR];
  acc_t  part_r   [NGRP];
  acc_t  part_nxt [NGRP];
  acc_t  sum_nxt;

  // One constant multiply per pair.
  always_comb begin
    for (int p = 0; p < NPAIR; p++) begin
      prod_nxt[p] = PROD_W'(pre_r[p]) * PROD_W'(COEF_Q16[p]);
    end
  end

  // First tree level: small groups of products.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_nxt[g] = '0;
      for (int i = 0; i < GRP; i++) begin
        if (g * GRP + i < NPAIR) begin
          part_nxt[g] = part_nxt[g] + ACC_W'(prod_r[g*GRP+i]);
        end
      end
    end
  end

  // Second tree level: the group sums.
  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum_nxt = sum_nxt + part_r[g];
    end
  end

  // Stage registers of the multiply and the tree.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod_r <= prod_nxt;
      part_r <= part_nxt;
      sum_r  <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ffir_sat.sv =====
// ----------------------------------------------------------------------------
// ffir_sat: Q16 scaling and saturation
// Divides the sum by 65536 with truncation toward zero and clamps the
// quotient to the signed sample range in the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffir_sat (
  input  logic                clk,
  input  ffir_pkg::ffir_ctl_t ctl,
  input  ffir_pkg::acc_t      sum_r,
  output ffir_pkg::sample_t   sample_r
);
  import ffir_pkg::*;

  localparam acc_t  BIAS    = ACC_W'((1 << DIV_SHIFT) - 1);
  localparam quot_t SAT_MAX = QUOT_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam quot_t SAT_MIN = -QUOT_W'(1 << (SAMPLE_W - 1));

  acc_t    biased;
  quot_t   quot;
  sample_t sample_nxt;

  // A negative sum is biased up before the shift so the quotient rounds
  // toward zero rather than toward minus infinity.
  always_comb begin
    biased = sum_r + (sum_r[ACC_W-1] ? BIAS : '0);
    quot   = signed'(biased[ACC_W-1:DIV_SHIFT]);
    if (quot > SAT_MAX) begin
      sample_nxt = SAMPLE_W'(SAT_MAX);
    end else if (quot < SAT_MIN) begin
      sample_nxt = SAMPLE_W'(SAT_MIN);
    end else begin
      sample_nxt = quot[SAMPLE_W-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      sample_r <= sample_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/framed_fir_filter.sv =====
// ----------------------------------------------------------------------------
// framed_fir_filter: 45-tap symmetric low-pass FIR over frames of samples
// Streams one signed 16-bit sample in and one filtered sample out; the
// delay line restarts from zero at every frame of 128 samples.
// ----------------------------------------------------------------------------
//
//   Channel | Ports                                  | Payload
//   --------+----------------------------------------+-------------------------
//   input   | in_valid, in_stall, in_sample_in       | signed 16-bit sample
//   output  | out_valid, out_stall, out_sample_out   | filtered signed sample
//
// One sample is accepted in every cycle that the result is not stalled; a sample passes the
// pre-add, multiply, two adder-tree levels and the scale and saturate register.
// Reset clears the frame position, the delay line and every stage valid bit.
// A stalled result freezes all stages together and raises in_stall in the
// same cycle; bubbles travel through the pipeline as invalid stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module framed_fir_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ffir_pkg::sample_t in_sample_in,
  output logic              out_valid,
  input  logic              out_stall,
  output ffir_pkg::sample_t out_sample_out
);
  import ffir_pkg::*;

  ffir_ctl_t ctl;
  pre_t      pre_r [NPAIR];
  acc_t      sum_r;
  logic      vld_pre_r;
  logic      vld_prod_r;
  logic      vld_part_r;
  logic      vld_sum_r;
  logic      out_valid_r;

  // The pipeline moves unless a finished result is being held.
  assign ctl.adv  = !(out_valid_r && out_stall);
  assign ctl.take = in_valid && ctl.adv;
  assign in_stall = !ctl.adv;
  assign out_valid = out_valid_r;

  // Valid bits that follow each transaction through the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_pre_r   <= 1'b0;
      vld_prod_r  <= 1'b0;
      vld_part_r  <= 1'b0;
      vld_sum_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_pre_r   <= in_valid;
      vld_prod_r  <= vld_pre_r;
      vld_part_r  <= vld_prod_r;
      vld_sum_r   <= vld_part_r;
      out_valid_r <= vld_sum_r;
    end
  end

  ffir_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_sample (in_sample_in),
    .pre_r     (pre_r)
  );

  ffir_mac u_mac (
    .clk   (clk),
    .ctl   (ctl),
    .pre_r (pre_r),
    .sum_r (sum_r)
  );

  ffir_sat u_sat (
    .clk      (clk),
    .ctl      (ctl),
    .sum_r    (sum_r),
    .sample_r (out_sample_out)
  );

endmodule

`default_nettype wire

// ===== rtl/ffir_checker.sv =====
// ----------------------------------------------------------------------------
// ffir_checker: port-level checks of the framed FIR filter
// Watches the two channels for stall coupling, payload hold on both sides,
// reset and stalls while no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "framed_fir_filter_macros.svh"

module ffir_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input ffir_pkg::sample_t in_sample_in,
  input logic              out_valid,
  input logic              out_stall,
  input ffir_pkg::sample_t out_sample_out
);

  logic in_held;
  logic out_held;

  // A transaction that waits on its channel.
  assign in_held  = in_valid && in_stall;
  assign out_held = out_valid && out_stall;

  // The input side stalls exactly when a result is held back.
  `FFIR_ASSERT(a_stall_coupling, clk, rst_n, in_stall == out_held, "bad in_stall")

  // A held result stays valid and unchanged.
  `FFIR_ASSERT(a_out_hold, clk, rst_n, out_held |=> out_valid && $stable(out_sample_out), "out moved")

  // A stalled input sample stays offered and unchanged.
  `FFIR_ASSERT(a_in_hold, clk, rst_n, in_held |=> in_valid && $stable(in_sample_in), "in moved")

  // Reset empties the pipeline.
  `FFIR_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "valid after reset")

  // Without a pending result the input side never stalls.
  `FFIR_ASSERT(a_no_stall_idle, clk, rst_n, !out_valid |-> !in_stall, "stall while empty")

endmodule

bind framed_fir_filter ffir_checker u_ffir_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_sample_in   (in_sample_in),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out)
);

`default_nettype wire
